### sv/ptts_pkg.sv
package ptts_pkg;

   // Field widths of the request and response beats
   localparam int MODE_W    = 2;
   localparam int SLOT_ID_W = 6;
   localparam int PERIOD_W  = 8;
   localparam int REPEAT_W  = 16;
   localparam int RUNS_W    = 16;

   // Request opcodes
   localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ARM  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FREE = 2'd2;

   // Repeat count that never runs out
   localparam logic signed [REPEAT_W-1:0] REPEAT_FOREVER = -16'sd1;
   localparam logic signed [REPEAT_W-1:0] REPEAT_ONE     = 16'sd1;

   // One slot table entry
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [REPEAT_W-1:0] remaining;
      logic [RUNS_W-1:0]   runs;
   } entry_type;

   // One response beat
   typedef struct packed {
      logic [SLOT_ID_W-1:0] fired_slot;
      logic [RUNS_W-1:0]    run_index;
      logic                 expired;
      logic                 last;
   } result_type;

   // Controller to datapath
   typedef struct packed {
      logic arm;
      logic free;
      logic tick;
      logic idx_clear;
      logic idx_next;
      logic mod_load;
      logic mod_step;
      logic fire;
      logic flush;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic armed_cur;
      logic period_zero;
      logic digit_last;
      logic rem_zero;
      logic idx_last;
      logic pending_valid;
      logic out_free;
   } status_type;

   // Eight steps of restoring remainder: fold one byte of the tick count into rem.
   // rem stays below period on entry and on exit.
   function automatic logic [PERIOD_W-1:0] mod_digit(input logic [PERIOD_W-1:0] rem,
                                                    input logic [7:0] digit,
                                                    input logic [PERIOD_W-1:0] period);
      logic [PERIOD_W:0]   part;
      logic [PERIOD_W-1:0] r;
      r = rem;
      for (int i = 7; i >= 0; i--) begin
         part = {r, digit[i]};
         if (part >= {1'b0, period}) begin
            part = part - {1'b0, period};
         end
         r = part[PERIOD_W-1:0];
      end
      return r;
   endfunction

endpackage

### sv/ptts_if.sv
// Request channel
interface ptts_req_if import ptts_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic [SLOT_ID_W-1:0]       slot_id;
   logic [PERIOD_W-1:0]        period;
   logic signed [REPEAT_W-1:0] repeat_count;

   modport source (output valid, output mode, output slot_id, output period,
                   output repeat_count, input ready);
   modport sink   (input valid, input mode, input slot_id, input period,
                   input repeat_count, output ready);
endinterface

// Response channel
interface ptts_rsp_if import ptts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SLOT_ID_W-1:0] fired_slot;
   logic [RUNS_W-1:0]    run_index;
   logic                 expired;
   logic                 last;

   modport source (output valid, output fired_slot, output run_index, output expired,
                   output last, input ready);
   modport sink   (input valid, input fired_slot, input run_index, input expired,
                   input last, output ready);
endinterface

### sv/ptts_ctrl.sv
module ptts_ctrl import ptts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   input  status_type        sts,
   output cmd_type           cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_EVAL   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       advance;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      advance   = 1'b0;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_TICK: begin
                     cmd.tick      = 1'b1;
                     cmd.idx_clear = 1'b1;
                     state_in      = S_CHECK;
                  end
                  MODE_ARM:  cmd.arm  = 1'b1;
                  MODE_FREE: cmd.free = 1'b1;
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            // empty slots advance the walk straight from this state
            if (sts.armed_cur) begin
               state_in = S_LOAD;
            end else begin
               advance = 1'b1;
            end
         end
         S_LOAD: begin
            if (sts.period_zero) begin
               advance = 1'b1;
            end else begin
               cmd.mod_load = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.mod_step = 1'b1;
            if (sts.digit_last) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            // hold the firing until the held-back beat can move on
            if (!sts.rem_zero) begin
               advance = 1'b1;
            end else if (!sts.pending_valid || sts.out_free) begin
               cmd.fire = 1'b1;
               advance  = 1'b1;
            end
         end
         S_FINISH: begin
            if (!sts.pending_valid) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // step to the next slot or close the walk
      if (advance) begin
         if (sts.idx_last) begin
            state_in = S_FINISH;
         end else begin
            cmd.idx_next = 1'b1;
            state_in     = S_CHECK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/ptts_datapath.sv
module ptts_datapath import ptts_pkg::*; #(
   parameter int SLOT_COUNT = 64,
   parameter int TICK_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 sts,
   input  logic [SLOT_ID_W-1:0]       req_slot_id,
   input  logic [PERIOD_W-1:0]        req_period,
   input  logic signed [REPEAT_W-1:0] req_repeat_count,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output result_type                 rsp_result
);

   localparam int SW     = $clog2(SLOT_COUNT);
   localparam int DIGITS = (TICK_WIDTH + 7) / 8;
   localparam int PAD_W  = DIGITS * 8;
   localparam int DCW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   // Slot table and its registered read port
   entry_type mem [SLOT_COUNT];
   entry_type rd_ff;

   logic [SLOT_COUNT-1:0] armed_ff, armed_in;
   logic [SW-1:0]         idx_ff, idx_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;

   logic [PAD_W-1:0]    shift_ff, shift_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [DCW-1:0]      digit_ff, digit_in;

   result_type pend_ff, pend_in;
   logic       pend_valid_ff, pend_valid_in;
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   logic                       arm_hit;
   logic [SW-1:0]              arm_addr;
   logic signed [REPEAT_W-1:0] rd_remaining;
   logic                       fire_forever;
   logic                       fire_expired;
   logic                       out_free;
   logic                       mem_we;
   logic [SW-1:0]              mem_addr;
   entry_type                  mem_wdata;
   result_type                 fire_result;

   assign arm_hit  = (32'(req_slot_id) < SLOT_COUNT);
   assign arm_addr = SW'(req_slot_id);

   // Firing of the current slot
   assign rd_remaining = $signed(rd_ff.remaining);
   assign fire_forever = (rd_remaining == REPEAT_FOREVER);
   assign fire_expired = !fire_forever && (rd_remaining <= REPEAT_ONE);

   always_comb begin
      fire_result.fired_slot = SLOT_ID_W'(idx_ff);
      fire_result.run_index  = rd_ff.runs;
      fire_result.expired    = fire_expired;
      fire_result.last       = 1'b0;
   end

   // Table write: arm from the request, or write back after a firing
   always_comb begin
      mem_we   = (cmd.arm && arm_hit) || cmd.fire;
      mem_addr = cmd.arm ? arm_addr : idx_ff;
      if (cmd.arm) begin
         mem_wdata.period    = req_period;
         mem_wdata.remaining = req_repeat_count;
         mem_wdata.runs      = '0;
      end else begin
         mem_wdata.period    = rd_ff.period;
         mem_wdata.remaining = fire_forever ? rd_ff.remaining : rd_ff.remaining - 1'b1;
         mem_wdata.runs      = rd_ff.runs + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[idx_ff];
   end

   // Armed flags, slot index and tick counter
   always_comb begin
      armed_in = armed_ff;
      if (cmd.arm && arm_hit) begin
         armed_in[arm_addr] = 1'b1;
      end
      if (cmd.free && arm_hit) begin
         armed_in[arm_addr] = 1'b0;
      end
      if (cmd.fire && fire_expired) begin
         armed_in[idx_ff] = 1'b0;
      end

      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_next) begin
         idx_in = idx_ff + 1'b1;
      end

      tick_in = cmd.tick ? tick_ff + 1'b1 : tick_ff;
   end

   // Tick count modulo period, one byte per cycle from the top
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      digit_in = digit_ff;
      if (cmd.mod_load) begin
         shift_in = PAD_W'(tick_ff);
         rem_in   = '0;
         digit_in = DCW'(DIGITS - 1);
      end else if (cmd.mod_step) begin
         shift_in = shift_ff << 8;
         rem_in   = mod_digit(rem_ff, shift_ff[PAD_W-1 -: 8], rd_ff.period);
         digit_in = digit_ff - 1'b1;
      end
   end

   // One beat is held back until the next firing or the end of the walk
   // decides its last flag
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      if (cmd.fire) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_valid_in = 1'b1;
         end
         pend_in       = fire_result;
         pend_valid_in = 1'b1;
      end else if (cmd.flush) begin
         out_in        = pend_ff;
         out_in.last   = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= '0;
         idx_ff        <= '0;
         tick_ff       <= '0;
         digit_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         armed_ff      <= armed_in;
         idx_ff        <= idx_in;
         tick_ff       <= tick_in;
         digit_ff      <= digit_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   // Status
   always_comb begin
      sts.armed_cur     = armed_ff[idx_ff];
      sts.period_zero   = (rd_ff.period == '0);
      sts.digit_last    = (digit_ff == '0);
      sts.rem_zero      = (rem_ff == '0);
      sts.idx_last      = (idx_ff == SW'(SLOT_COUNT - 1));
      sts.pending_valid = pend_valid_ff;
      sts.out_free      = out_free;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

### sv/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler.
// req_bus carries one beat per command: tick, arm slot or free slot. Arm and free
// take effect in idle and produce no response. A tick advances the wrapping tick counter
// and walks all slots in order; every armed slot whose nonzero period divides the
// new count fires one rsp_bus beat (slot id, run index, expired), and the final beat
// of a tick carries last. A tick that fires nothing produces no beat.
// A tick is accepted, then the walk visits each slot: an empty slot is skipped, an armed
// slot of zero period is skipped once its entry is read, and any other armed slot has
// the tick count reduced modulo its period over DIGITS = ceil(TICK_WIDTH/8) bytes and
// is then evaluated; a final step closes the walk. The byte-wide remainder unit folds
// eight bits of the tick count into the remainder per cycle.
// req_bus.ready is high only while no tick walk is in progress.
// Responses pass through a one-beat output register plus one held-back beat; when
// rsp_bus stalls, the walk waits at the next firing until a register frees up.
// Reset (synchronous) clears the tick counter and disarms every slot; the slot
// table itself is not cleared, as arming writes a whole entry.
module periodic_task_tick_scheduler import ptts_pkg::*; #(
   parameter int SLOT_COUNT = 64,
   parameter int TICK_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   ptts_req_if.sink   req_bus,
   ptts_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type sts;
   logic       ctl_ready;
   logic       dp_valid;
   result_type dp_result;

   ptts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (ctl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptts_datapath #(
      .SLOT_COUNT (SLOT_COUNT),
      .TICK_WIDTH (TICK_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_slot_id      (req_bus.slot_id),
      .req_period       (req_bus.period),
      .req_repeat_count (req_bus.repeat_count),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (dp_valid),
      .rsp_result       (dp_result)
   );

   assign req_bus.ready      = ctl_ready;
   assign rsp_bus.valid      = dp_valid;
   assign rsp_bus.fired_slot = dp_result.fired_slot;
   assign rsp_bus.run_index  = dp_result.run_index;
   assign rsp_bus.expired    = dp_result.expired;
   assign rsp_bus.last       = dp_result.last;

   // No held-back beat survives into idle
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !sts.pending_valid)
      else $error("held-back beat left over while idle");

   // A tick blocks further commands on the next cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.mode == MODE_TICK) |=> !req_bus.ready)
      else $error("ready high right after a tick");

   // Only armed slots with a zero remainder fire
   a_fire_armed: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> (sts.armed_cur && sts.rem_zero && !sts.period_zero))
      else $error("firing of a slot that does not match");

   // The final beat only moves into a free output register
   a_flush_room: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> (sts.pending_valid && sts.out_free))
      else $error("last beat pushed without room");

endmodule

### verif/tb.sv
module tb;
   import ptts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS      = 64;
   localparam int ITEMS_PER_PHASE = 57;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 600;
   localparam int MAX_REPORTS    = 10;

   // Opcode the block must ignore
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Idle and stall percentages per phase
   localparam int REQ_IDLE_PCT[4]  = '{0, 58, 0, 37};
   localparam int RSP_STALL_PCT[4] = '{0, 0, 58, 37};

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [SLOT_ID_W-1:0] slot_id;
      logic [PERIOD_W-1:0]  period;
      logic [REPEAT_W-1:0]  repeat_count;
   } sched_cmd_type;

   // How a directed row is checked
   typedef enum logic [1:0] {
      ROW_PREDICTED,
      ROW_SILENT,
      ROW_SINGLE
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      sched_cmd_type cmd;
      result_type    want;
   } stim_row_type;

   localparam int NUM_ROWS = 23;

   // Directed rows: tick counts follow from the order of the ticks
   localparam stim_row_type DIRECTED[NUM_ROWS] = '{
      // tick 1, table empty
      '{ROW_SILENT,    '{MODE_TICK, 6'd0,  8'd0,   16'h0000},       '0},
      // slot 0 fires every tick, forever
      '{ROW_SILENT,    '{MODE_ARM,  6'd0,  8'd1,   REPEAT_FOREVER}, '0},
      '{ROW_SINGLE,    '{MODE_TICK, 6'd0,  8'd0,   16'h0000},       '{6'd0, 16'd0, 1'b0, 1'b1}},
      // top slot, widest period and largest count
      '{ROW_SILENT,    '{MODE_ARM,  6'd63, 8'd255, 16'h7FFF},       '0},
      // zero period stays armed, never fires
      '{ROW_SILENT,    '{MODE_ARM,  6'd5,  8'd0,   16'h0003},       '0},
      '{ROW_SINGLE,    '{MODE_TICK, 6'd0,  8'd0,   16'h0000},       '{6'd0, 16'd1, 1'b0, 1'b1}},
      // zero and most negative counts fire once, then expire
      '{ROW_SILENT,    '{MODE_ARM,  6'd10, 8'd2,   16'h0000},       '0},
      '{ROW_SILENT,    '{MODE_ARM,  6'd11, 8'd2,   16'h8000},       '0},
      '{ROW_PREDICTED, '{MODE_TICK, 6'd0,  8'd0,   16'h0000},       '0},
      '{ROW_SINGLE,    '{MODE_TICK, 6'd0,  8'd0,   16'h0000},       '{6'd0, 16'd3, 1'b0, 1'b1}},
      // re-arm an armed slot: run index restarts
      '{ROW_SILENT,    '{MODE_ARM,  6'd0,  8'd1,   16'h0002},       '0},
      '{ROW_SINGLE,    '{MODE_TICK, 6'd0,  8'd0,   16'h0000},       '{6'd0, 16'd0, 1'b0, 1'b1}},
      '{ROW_SINGLE,    '{MODE_TICK, 6'd0,  8'd0,   16'h0000},       '{6'd0, 16'd1, 1'b1, 1'b1}},
      // tick that fires nothing
      '{ROW_SILENT,    '{MODE_TICK, 6'd0,  8'd0,   16'h0000},       '0},
      // free of an empty slot, unused opcode
      '{ROW_SILENT,    '{MODE_FREE, 6'd20, 8'd0,   16'h0000},       '0},
      '{ROW_SILENT,    '{MODE_UNUSED, 6'd63, 8'd255, 16'hFFFF},     '0},
      // free before the first firing
      '{ROW_SILENT,    '{MODE_ARM,  6'd3,  8'd3,   REPEAT_ONE},     '0},
      '{ROW_SILENT,    '{MODE_ARM,  6'd4,  8'd9,   REPEAT_FOREVER}, '0},
      '{ROW_SILENT,    '{MODE_FREE, 6'd3,  8'd0,   16'h0000},       '0},
      '{ROW_SINGLE,    '{MODE_TICK, 6'd0,  8'd0,   16'h0000},       '{6'd4, 16'd0, 1'b0, 1'b1}},
      '{ROW_SILENT,    '{MODE_FREE, 6'd4,  8'd0,   16'h0000},       '0},
      '{ROW_SILENT,    '{MODE_TICK, 6'd0,  8'd0,   16'h0000},       '0},
      '{ROW_SILENT,    '{MODE_FREE, 6'd5,  8'd0,   16'h0000},       '0}
   };

   logic clock;
   logic reset;

   ptts_req_if req_bus ();
   ptts_rsp_if rsp_bus ();

   periodic_task_tick_scheduler dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Scheduler shadow state
   logic [31:0]         ticks_seen = '0;
   bit                  slot_live[NUM_SLOTS];
   logic [PERIOD_W-1:0] slot_every[NUM_SLOTS];
   int                  slot_left[NUM_SLOTS];
   logic [RUNS_W-1:0]   slot_runs_done[NUM_SLOTS];

   result_type pending_fires[$];
   int         fault_count = 0;
   int         req_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void note_fault(input string msg);
      if (fault_count < MAX_REPORTS) begin
         $display("%0t: %s", $realtime, msg);
      end
      fault_count++;
   endfunction

   // Apply one command to the shadow table; a tick returns its firings in slot order
   function automatic void advance_schedule(input sched_cmd_type cmd,
                                            ref result_type fires[$]);
      result_type r;
      fires.delete();
      case (cmd.mode)
         MODE_ARM: begin
            slot_live[cmd.slot_id]      = 1'b1;
            slot_every[cmd.slot_id]     = cmd.period;
            slot_left[cmd.slot_id]      = $signed(cmd.repeat_count);
            slot_runs_done[cmd.slot_id] = '0;
         end
         MODE_FREE: begin
            slot_live[cmd.slot_id] = 1'b0;
         end
         MODE_TICK: begin
            ticks_seen = ticks_seen + 32'd1;
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (slot_live[s] && slot_every[s] != '0 &&
                   (ticks_seen % {24'd0, slot_every[s]}) == 32'd0) begin
                  r.fired_slot = SLOT_ID_W'(s);
                  r.run_index  = slot_runs_done[s];
                  r.expired    = 1'b0;
                  r.last       = 1'b0;
                  slot_runs_done[s] = slot_runs_done[s] + RUNS_W'(1);
                  // finite slot: count down, free at zero or below
                  if (slot_left[s] != -1) begin
                     slot_left[s] = slot_left[s] - 1;
                     if (slot_left[s] <= 0) begin
                        slot_live[s] = 1'b0;
                        r.expired    = 1'b1;
                     end
                  end
                  fires.push_back(r);
               end
            end
            if (fires.size() > 0) begin
               r = fires[fires.size()-1];
               r.last = 1'b1;
               fires[fires.size()-1] = r;
            end
         end
         default: ;
      endcase
   endfunction

   // Random command: mostly arms with short periods and ticks, some noise
   function automatic sched_cmd_type random_cmd();
      sched_cmd_type c;
      int pick;
      int cnt;
      pick = $urandom_range(99);
      c.mode    = (pick < 45) ? MODE_TICK : (pick < 80) ? MODE_ARM :
                  (pick < 96) ? MODE_FREE : MODE_UNUSED;
      c.slot_id = SLOT_ID_W'($urandom_range(NUM_SLOTS-1));
      pick = $urandom_range(99);
      if (pick < 10)      c.period = '0;
      else if (pick < 75) c.period = PERIOD_W'($urandom_range(6, 1));
      else if (pick < 90) c.period = PERIOD_W'($urandom_range(20, 7));
      else                c.period = PERIOD_W'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 30)      cnt = -1;
      else if (pick < 70) cnt = $urandom_range(6, 1);
      else if (pick < 80) cnt = -int'($urandom_range(127));
      else if (pick < 85) cnt = 32767;
      else if (pick < 90) cnt = -32768;
      else                cnt = $urandom_range(65535);
      c.repeat_count = REPEAT_W'(cnt);
      return c;
   endfunction

   // Drive one request beat; entered and left at a falling edge
   task automatic send_cmd(input sched_cmd_type cmd, input row_kind_type kind,
                           input result_type want);
      result_type fires[$];
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= cmd.mode;
      req_bus.slot_id      <= cmd.slot_id;
      req_bus.period       <= cmd.period;
      req_bus.repeat_count <= cmd.repeat_count;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      advance_schedule(cmd, fires);
      case (kind)
         ROW_SINGLE:    pending_fires.push_back(want);
         ROW_PREDICTED: foreach (fires[i]) pending_fires.push_back(fires[i]);
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Response ready, changed at the falling edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Response check
   always @(posedge clock) begin : check_rsp
      result_type got;
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.fired_slot, rsp_bus.run_index, rsp_bus.expired, rsp_bus.last};
         if (pending_fires.size() == 0) begin
            note_fault($sformatf("unexpected beat: slot %0d run %0d expired %0b last %0b",
                                 got.fired_slot, got.run_index, got.expired, got.last));
         end else begin
            want = pending_fires.pop_front();
            if (got.fired_slot !== want.fired_slot || got.run_index !== want.run_index ||
                got.expired !== want.expired || got.last !== want.last) begin
               note_fault($sformatf({"mismatch: expected slot %0d run %0d expired %0b last %0b,",
                                     " got slot %0d run %0d expired %0b last %0b"},
                                    want.fired_slot, want.run_index, want.expired, want.last,
                                    got.fired_slot, got.run_index, got.expired, got.last));
            end
         end
      end
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_TICK;
      req_bus.slot_id      = '0;
      req_bus.period       = '0;
      req_bus.repeat_count = '0;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, no idling
      for (int i = 0; i < NUM_ROWS; i++) begin
         send_cmd(DIRECTED[i].cmd, DIRECTED[i].kind, DIRECTED[i].want);
      end

      // random part over the four phases of idle and stall percentages
      for (int p = 0; p < 4; p++) begin
         req_idle_pct  = REQ_IDLE_PCT[p];
         rsp_stall_pct = RSP_STALL_PCT[p];
         repeat (ITEMS_PER_PHASE) send_cmd(random_cmd(), ROW_PREDICTED, '0);
      end
      req_bus.valid <= 1'b0;

      while (pending_fires.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_fires.size() != 0) begin
         note_fault($sformatf("%0d expected beats never arrived", pending_fires.size()));
      end

      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
